/* sv/phpv_pkg.sv */
package phpv_pkg;

  // header layout
  localparam int HEADER_BYTES = 26;
  localparam int HEADER_BITS  = 8 * HEADER_BYTES;
  localparam int POS_W        = 5;

  // queue between parser front and checker back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_SIGNATURE = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_CHANNELS  = 4'd4;
  localparam logic [3:0] ST_HEIGHT    = 4'd5;
  localparam logic [3:0] ST_WIDTH     = 4'd6;
  localparam logic [3:0] ST_SIZE      = 4'd7;
  localparam logic [3:0] ST_MODE      = 4'd8;
  localparam logic [3:0] ST_DEPTH     = 4'd9;

  // configuration register indexes
  localparam logic [7:0] CFG_CHANNEL_LIMIT   = 8'd0;
  localparam logic [7:0] CFG_DIMENSION_LIMIT = 8'd1;

  localparam logic [15:0] CHANNEL_LIMIT_RESET   = 16'd56;
  localparam logic [30:0] DIMENSION_LIMIT_RESET = 31'd262144;

  // expected signature "8BPS"
  localparam logic [31:0] SIGNATURE = 32'h3842_5053;

  // accepted codes
  localparam logic [15:0] VERSION_ONE = 16'd1;
  localparam logic [15:0] MODE_BITMAP = 16'd0;
  localparam logic [15:0] MODE_GREY   = 16'd1;
  localparam logic [15:0] MODE_INDEX  = 16'd2;
  localparam logic [15:0] MODE_RGB    = 16'd3;
  localparam logic [15:0] MODE_MULTI  = 16'd8;
  localparam logic [15:0] DEPTH_1     = 16'd1;
  localparam logic [15:0] DEPTH_8     = 16'd8;
  localparam logic [15:0] DEPTH_16    = 16'd16;

  // one parsed header (or a truncation mark) on its way to the checks
  typedef struct packed {
    logic        truncated;
    logic [31:0] signature;
    logic [15:0] version;
    logic [15:0] channels;
    logic [31:0] rows;
    logic [31:0] cols;
    logic [15:0] depth;
    logic [15:0] mode;
  } rec_t;

  // configuration registers as seen by the checks
  typedef struct packed {
    logic [15:0] channel_limit;
    logic [30:0] dimension_limit;
  } cfg_t;

endpackage

/* sv/psd_header_parse_validate.sv */
// result path: the item that completes the header (or carries end of stream) is
// written into the queue, then registered in the check stage and the output register
// throughput: one byte item per cycle; the front takes items while the queue has room
// and the two-stage check pipeline drains one record per cycle while m_tready is set
// reset: clears byte position, queue, pipeline valids; limits return to 56 and 262144
module psd_header_parse_validate #(
  parameter int QUEUE_DEPTH = phpv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] byte_value
  input  logic         s_tlast,   // end_of_stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] status, [19:4] channel_count, [51:20] image_height,
  // [83:52] image_width, [99:84] bit_depth, [115:100] image_mode, [119:116] zero
  output logic [119:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  phpv_pkg::cfg_t cfg;
  phpv_pkg::rec_t push_rec;
  phpv_pkg::rec_t pop_rec;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_limit   <= phpv_pkg::CHANNEL_LIMIT_RESET;
      cfg.dimension_limit <= phpv_pkg::DIMENSION_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        phpv_pkg::CFG_CHANNEL_LIMIT:   cfg.channel_limit   <= cfg_data[15:0];
        phpv_pkg::CFG_DIMENSION_LIMIT: cfg.dimension_limit <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  phpv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  phpv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (pop_rec)
  );

  phpv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_rec       (pop_rec),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

/* sv/phpv_front.sv */
module phpv_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] byte_value
  input  logic               s_tlast,   // end_of_stream
  input  logic               q_full,
  output logic               q_push,
  output phpv_pkg::rec_t     q_rec
);

  localparam int SHIFT_BITS = phpv_pkg::HEADER_BITS - 8;

  logic [phpv_pkg::POS_W-1:0]       pos;
  logic [SHIFT_BITS-1:0]            hdr_shift;
  logic [phpv_pkg::HEADER_BITS-1:0] hdr_full;
  logic                             accept;
  logic                             last_byte;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign last_byte = (pos == phpv_pkg::POS_W'(phpv_pkg::HEADER_BYTES - 1));
  assign q_push    = accept && (s_tlast || last_byte);

  // first header byte sits in the top bits
  assign hdr_full = {hdr_shift, s_tdata};

  // byte position in the header
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (s_tlast || last_byte) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // header bytes shift line
  always_ff @(posedge clk) begin
    if (accept && !s_tlast) begin
      hdr_shift <= hdr_full[SHIFT_BITS-1:0];
    end
  end

  // split the header into its big-endian fields, zeros on truncation
  always_comb begin
    q_rec = '0;
    if (s_tlast) begin
      q_rec.truncated = 1'b1;
    end else begin
      q_rec.signature = hdr_full[207:176];
      q_rec.version   = hdr_full[175:160];
      q_rec.channels  = hdr_full[111:96];
      q_rec.rows      = hdr_full[95:64];
      q_rec.cols      = hdr_full[63:32];
      q_rec.depth     = hdr_full[31:16];
      q_rec.mode      = hdr_full[15:0];
    end
  end

endmodule

/* sv/phpv_queue.sv */
module phpv_queue #(
  parameter int DEPTH = phpv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  phpv_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output phpv_pkg::rec_t pop_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  phpv_pkg::rec_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_rec   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/phpv_back.sv */
module phpv_back (
  input  logic           clk,
  input  logic           rst,
  input  phpv_pkg::cfg_t cfg,
  input  logic           q_not_empty,
  input  phpv_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  // [3:0] status, [19:4] channel_count, [51:20] image_height,
  // [83:52] image_width, [99:84] bit_depth, [115:100] image_mode, [119:116] zero
  output logic [119:0]   m_tdata
);

  // check stage registers
  logic           s1_valid;
  phpv_pkg::rec_t s1_rec;
  logic           s1_sig_bad;
  logic           s1_ver_bad;
  logic           s1_ch_bad;
  logic           s1_rows_bad;
  logic           s1_cols_bad;
  logic           s1_mode_bad;
  logic           s1_depth_bad;
  logic [61:0]    s1_product;

  logic           out_adv;
  logic           s1_adv;
  logic [31:0]    dim_limit;
  logic [3:0]     status_next;

  assign out_adv   = !m_tvalid || m_tready;
  assign s1_adv    = !s1_valid || out_adv;
  assign q_pop     = q_not_empty && s1_adv;
  assign dim_limit = {1'b0, cfg.dimension_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= q_not_empty;
    end
  end

  // field checks and size product; factors only matter below 2^31
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rec       <= q_rec;
      s1_sig_bad   <= (q_rec.signature != phpv_pkg::SIGNATURE);
      s1_ver_bad   <= (q_rec.version != phpv_pkg::VERSION_ONE);
      s1_ch_bad    <= (q_rec.channels > cfg.channel_limit);
      s1_rows_bad  <= (q_rec.rows == '0) || (q_rec.rows > dim_limit);
      s1_cols_bad  <= (q_rec.cols == '0) || (q_rec.cols > dim_limit);
      s1_mode_bad  <= !((q_rec.mode == phpv_pkg::MODE_BITMAP) ||
                        (q_rec.mode == phpv_pkg::MODE_GREY) ||
                        (q_rec.mode == phpv_pkg::MODE_INDEX) ||
                        (q_rec.mode == phpv_pkg::MODE_RGB) ||
                        (q_rec.mode == phpv_pkg::MODE_MULTI));
      s1_depth_bad <= !((q_rec.depth == phpv_pkg::DEPTH_1) ||
                        (q_rec.depth == phpv_pkg::DEPTH_8) ||
                        (q_rec.depth == phpv_pkg::DEPTH_16));
      s1_product   <= 62'(q_rec.rows[30:0]) * 62'(q_rec.cols[30:0]);
    end
  end

  // first failing check wins: truncation, signature, version, channels, height, width, size, mode, depth
  always_comb begin
    if (s1_rec.truncated) begin
      status_next = phpv_pkg::ST_TRUNCATED;
    end else if (s1_sig_bad) begin
      status_next = phpv_pkg::ST_SIGNATURE;
    end else if (s1_ver_bad) begin
      status_next = phpv_pkg::ST_VERSION;
    end else if (s1_ch_bad) begin
      status_next = phpv_pkg::ST_CHANNELS;
    end else if (s1_rows_bad) begin
      status_next = phpv_pkg::ST_HEIGHT;
    end else if (s1_cols_bad) begin
      status_next = phpv_pkg::ST_WIDTH;
    end else if (s1_product[61:31] != '0) begin
      status_next = phpv_pkg::ST_SIZE;
    end else if (s1_mode_bad) begin
      status_next = phpv_pkg::ST_MODE;
    end else if (s1_depth_bad) begin
      status_next = phpv_pkg::ST_DEPTH;
    end else begin
      status_next = phpv_pkg::ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata <= {4'b0000, s1_rec.mode, s1_rec.depth, s1_rec.cols, s1_rec.rows,
                  s1_rec.channels, status_next};
    end
  end

endmodule
